FILE: hdl/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg
// shared constants, codes and state type of the sparse incomplete cholesky
// ----------------------------------------------------------------------------
package sic_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int MAX_ROWS    = 256;
    localparam int FRAC_BITS   = 24;

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int EC_W   = $clog2(MAX_ENTRIES + 1);
    localparam int RC_W   = $clog2(MAX_ROWS + 1);
    localparam int VAL_W  = 32;
    localparam int COL_W  = 8;
    localparam int POS_W  = 12;
    localparam int CODE_W = 3;
    localparam int IN_W   = 64;
    localparam int OUT_W  = 40;

    localparam logic [CODE_W-1:0] ERR_NONE  = 3'd0;
    localparam logic [CODE_W-1:0] ERR_ABOVE = 3'd1;
    localparam logic [CODE_W-1:0] ERR_PIVOT = 3'd2;
    localparam logic [CODE_W-1:0] ERR_CAP   = 3'd3;
    localparam logic [CODE_W-1:0] ERR_SAT   = 3'd4;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_READ    = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_LOAD,
        F_START, F_ROW0, F_ROW1, F_ROW2,
        F_ENT0, F_ENT1, F_ENT2, F_ENT3,
        F_MA, F_MB, F_MC, F_ACC,
        F_NUM, F_CHK, F_PV, F_DIV, F_SQ, F_WR, F_DONE
    } t_state;

endpackage

FILE: hdl/sic_ram.sv
// ----------------------------------------------------------------------------
// sic_ram
// generic simple dual port ram, one write port, registered read port
// ----------------------------------------------------------------------------
module sic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/sparse_incomplete_cholesky.sv
// read request: result valid after the S_RD state, next transfer once it is taken
// load: S_LOAD writes one row start per row that the entry skips over, then stores the entry
// factorization: each stored entry passes the F_ENT states and a merge (F_MA, F_MB, F_MC,
// F_ACC on a match), then an off-diagonal division or diagonal square root, one bit per cycle
// reset clears the state, counters, error and output valid; the stores are not cleared
// ----------------------------------------------------------------------------
// sparse_incomplete_cholesky
// loads a sparse lower triangle, factorizes it in place with zero fill,
// reports one status and serves reads of factor entries
// ----------------------------------------------------------------------------
module sparse_incomplete_cholesky
    import sic_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // entry_row, entry_col, entry_value, read_position
    input  logic             s_axis_tuser,  // req_type
    input  logic             s_axis_tlast,  // last_entry
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,  // factor_value, status_code
    output logic             m_axis_tuser   // result_kind
);

    t_state r_state, n_state;
    logic [EC_W-1:0]   r_ec, n_ec;
    logic [RC_W-1:0]   r_rc, n_rc;
    logic [CODE_W-1:0] r_err, n_err;
    logic              r_factored, n_factored;
    logic              r_ov, n_ov;
    logic              r_okind, n_okind;
    logic [VAL_W-1:0]  r_oval, n_oval;
    logic [CODE_W-1:0] r_ocode, n_ocode;

    logic [7:0]        r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [VAL_W-1:0]  r_val, n_val;
    logic              r_last, n_last;
    logic              r_rdok, n_rdok;

    logic [RC_W-1:0]   r_i, n_i;
    logic [EC_W-1:0]   r_s, n_s, r_e, n_e, r_j, n_j;
    logic [EC_W-1:0]   r_ks, n_ks, r_ke, n_ke, r_pa, n_pa, r_pb, n_pb;
    logic [COL_W-1:0]  r_k, n_k, r_ca, n_ca;
    logic signed [VAL_W-1:0] r_a, n_a, r_va, n_va;
    logic signed [63:0] r_acc, n_acc, r_prod, n_prod, r_num, n_num;
    logic [30:0]       r_piv, n_piv;
    logic [31:0]       r_rem, n_rem;
    logic [63:0]       r_quo, n_quo;
    logic [5:0]        r_cnt, n_cnt;
    logic              r_neg, n_neg, r_isdiv, n_isdiv;
    logic [63:0]       r_x, n_x, r_r, n_r, r_bit, n_bit;

    logic              v_we, col_we;
    logic [ADDR_W-1:0] v_waddr, v_raddr;
    logic [VAL_W-1:0]  v_wdata, v_rdata;
    logic [COL_W-1:0]  c_rdata;
    logic              rs_we;
    logic [RC_W-1:0]   rs_waddr, rs_raddr;
    logic [EC_W-1:0]   rs_wdata, rs_rdata;

    logic signed [64:0] sum65, diff65, res65;
    logic signed [63:0] prod_c, ash;
    logic [32:0]        dtry;
    logic [63:0]        sq_t, mag;
    logic               cap, above, decr, done_load, in_acc;

    function automatic logic [CODE_W-1:0] f_note(input logic [CODE_W-1:0] cur,
                                                 input logic [CODE_W-1:0] code);
        f_note = (cur == ERR_NONE) ? code : cur;
    endfunction

    sic_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_value (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    sic_ram #(.WIDTH(COL_W), .DEPTH(MAX_ENTRIES)) u_column (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(v_waddr), .i_wdata(r_col),
        .i_raddr(v_raddr), .o_rdata(c_rdata)
    );

    sic_ram #(.WIDTH(EC_W), .DEPTH(MAX_ROWS + 1)) u_row_start (
        .i_clk(i_clk), .i_we(rs_we), .i_waddr(rs_waddr), .i_wdata(rs_wdata),
        .i_raddr(rs_raddr), .o_rdata(rs_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_ov;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = {{(OUT_W - VAL_W - CODE_W){1'b0}}, r_ocode, r_oval};

    always_comb begin
        cap   = (RC_W'(r_row) >= RC_W'(MAX_ROWS)) || (r_ec >= EC_W'(MAX_ENTRIES));
        above = r_col > r_row;
        decr  = (r_rc != '0) && (RC_W'(r_row) < r_rc - 1'b1);
        prod_c = r_va * signed'(v_rdata);
        sum65  = {r_acc[63], r_acc} + {r_prod[63], r_prod};
        ash    = 64'(r_a) <<< FRAC_BITS;
        diff65 = {ash[63], ash} - {r_acc[63], r_acc};
        dtry   = {r_rem, r_quo[63]};
        sq_t   = r_r + r_bit;
        mag    = r_num[63] ? (64'd0 - r_num) : r_num;
        res65  = r_isdiv ? (r_neg ? -signed'({1'b0, r_quo}) : signed'({1'b0, r_quo}))
                         : signed'({1'b0, r_r});
    end

    always_comb begin
        n_state = r_state; n_ec = r_ec; n_rc = r_rc; n_err = r_err;
        n_factored = r_factored; n_ov = r_ov; n_okind = r_okind;
        n_oval = r_oval; n_ocode = r_ocode;
        n_row = r_row; n_col = r_col; n_val = r_val; n_last = r_last; n_rdok = r_rdok;
        n_i = r_i; n_s = r_s; n_e = r_e; n_j = r_j; n_ks = r_ks; n_ke = r_ke;
        n_pa = r_pa; n_pb = r_pb; n_k = r_k; n_ca = r_ca; n_a = r_a; n_va = r_va;
        n_acc = r_acc; n_prod = r_prod; n_num = r_num; n_piv = r_piv;
        n_rem = r_rem; n_quo = r_quo; n_cnt = r_cnt; n_neg = r_neg; n_isdiv = r_isdiv;
        n_x = r_x; n_r = r_r; n_bit = r_bit;
        v_we = 1'b0; col_we = 1'b0; v_waddr = r_ec[ADDR_W-1:0]; v_wdata = r_val;
        v_raddr = r_j[ADDR_W-1:0];
        rs_we = 1'b0; rs_waddr = r_rc; rs_wdata = r_ec; rs_raddr = r_i;
        done_load = 1'b0;

        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                v_raddr = s_axis_tdata[48 +: ADDR_W];
                if (in_acc) begin
                    if (s_axis_tuser == REQ_READ) begin
                        n_rdok  = EC_W'(s_axis_tdata[48 +: POS_W]) < r_ec;
                        n_state = S_RD;
                    end else begin
                        n_row  = s_axis_tdata[7:0];
                        n_col  = s_axis_tdata[15:8];
                        n_val  = s_axis_tdata[47:16];
                        n_last = s_axis_tlast;
                        if (r_factored) begin
                            n_ec = '0; n_rc = '0; n_err = ERR_NONE; n_factored = 1'b0;
                        end
                        n_state = S_LOAD;
                    end
                end
            end
            S_RD: begin
                n_ov    = 1'b1;
                n_okind = KIND_DATA;
                n_oval  = r_rdok ? v_rdata : '0;
                n_ocode = ERR_NONE;
                n_state = S_IDLE;
            end
            S_LOAD: begin
                if (cap) begin
                    n_err = f_note(r_err, ERR_CAP); done_load = 1'b1;
                end else if (above) begin
                    n_err = f_note(r_err, ERR_ABOVE); done_load = 1'b1;
                end else if (decr) begin
                    done_load = 1'b1;
                end else if (r_rc <= RC_W'(r_row)) begin
                    rs_we = 1'b1;
                    n_rc  = r_rc + 1'b1;
                end else begin
                    v_we = 1'b1; col_we = 1'b1;
                    n_ec = r_ec + 1'b1;
                    done_load = 1'b1;
                end
                if (done_load) begin
                    n_state = r_last ? F_START : S_IDLE;
                end
            end
            F_START: begin
                rs_we   = 1'b1;
                n_i     = '0;
                n_state = F_ROW0;
            end
            F_ROW0: begin
                rs_raddr = r_i;
                n_state  = (r_i == r_rc) ? F_DONE : F_ROW1;
            end
            F_ROW1: begin
                rs_raddr = r_i + 1'b1;
                n_s      = rs_rdata;
                n_state  = F_ROW2;
            end
            F_ROW2: begin
                n_e = rs_rdata; n_j = r_s; n_state = F_ENT0;
            end
            F_ENT0: begin
                v_raddr = r_j[ADDR_W-1:0];
                if (r_j >= r_e) begin
                    n_i = r_i + 1'b1; n_state = F_ROW0;
                end else begin
                    n_state = F_ENT1;
                end
            end
            F_ENT1: begin
                rs_raddr = RC_W'(c_rdata);
                n_k = c_rdata; n_a = v_rdata;
                if (RC_W'(c_rdata) > r_i) begin
                    n_j = r_j + 1'b1; n_state = F_ENT0;
                end else begin
                    n_state = F_ENT2;
                end
            end
            F_ENT2: begin
                rs_raddr = RC_W'(r_k) + 1'b1;
                n_ks = rs_rdata; n_state = F_ENT3;
            end
            F_ENT3: begin
                n_ke = rs_rdata; n_pa = r_s; n_pb = r_ks; n_acc = '0; n_state = F_MA;
            end
            F_MA: begin
                v_raddr = r_pa[ADDR_W-1:0];
                n_state = ((r_pa < r_e) && (r_pb < r_ke)) ? F_MB : F_NUM;
            end
            F_MB: begin
                v_raddr = r_pb[ADDR_W-1:0];
                n_ca = c_rdata; n_va = v_rdata; n_state = F_MC;
            end
            F_MC: begin
                if (r_ca >= r_k || c_rdata >= r_k) begin
                    n_state = F_NUM;
                end else if (r_ca == c_rdata) begin
                    n_prod = prod_c; n_pa = r_pa + 1'b1; n_pb = r_pb + 1'b1;
                    n_state = F_ACC;
                end else if (r_ca < c_rdata) begin
                    n_pa = r_pa + 1'b1; n_state = F_MA;
                end else begin
                    n_pb = r_pb + 1'b1; n_state = F_MA;
                end
            end
            F_ACC: begin
                if (sum65[64] != sum65[63]) begin
                    n_err = f_note(r_err, ERR_SAT);
                    n_acc = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end else begin
                    n_acc = sum65[63:0];
                end
                n_state = F_MA;
            end
            F_NUM: begin
                if (diff65[64] != diff65[63]) begin
                    n_err = f_note(r_err, ERR_SAT);
                    n_num = diff65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end else begin
                    n_num = diff65[63:0];
                end
                n_state = F_CHK;
            end
            F_CHK: begin
                v_raddr = r_ke[ADDR_W-1:0] - 1'b1;
                v_waddr = r_j[ADDR_W-1:0];
                v_wdata = '0;
                if (r_k == r_j[COL_W-1:0] && RC_W'(r_k) == r_i) begin
                    n_isdiv = 1'b0;
                    if (r_num[63] || r_num == '0) begin
                        n_err = f_note(r_err, ERR_PIVOT); v_we = 1'b1;
                        n_j = r_j + 1'b1; n_state = F_ENT0;
                    end else begin
                        n_x = r_num; n_r = '0; n_bit = 64'd1 << 62; n_state = F_SQ;
                    end
                end else if (RC_W'(r_k) == r_i) begin
                    n_isdiv = 1'b0;
                    if (r_num[63] || r_num == '0) begin
                        n_err = f_note(r_err, ERR_PIVOT); v_we = 1'b1;
                        n_j = r_j + 1'b1; n_state = F_ENT0;
                    end else begin
                        n_x = r_num; n_r = '0; n_bit = 64'd1 << 62; n_state = F_SQ;
                    end
                end else if (r_ke > r_ks) begin
                    n_state = F_PV;
                end else begin
                    n_err = f_note(r_err, ERR_PIVOT); v_we = 1'b1;
                    n_j = r_j + 1'b1; n_state = F_ENT0;
                end
            end
            F_PV: begin
                v_waddr = r_j[ADDR_W-1:0];
                v_wdata = '0;
                if (c_rdata == r_k && !v_rdata[VAL_W-1] && v_rdata != '0) begin
                    n_isdiv = 1'b1; n_neg = r_num[63]; n_quo = mag; n_rem = '0;
                    n_piv = v_rdata[30:0]; n_cnt = '0; n_state = F_DIV;
                end else begin
                    n_err = f_note(r_err, ERR_PIVOT); v_we = 1'b1;
                    n_j = r_j + 1'b1; n_state = F_ENT0;
                end
            end
            F_DIV: begin
                if (dtry >= {2'b00, r_piv}) begin
                    n_rem = 32'(dtry - {2'b00, r_piv});
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = dtry[31:0];
                    n_quo = {r_quo[62:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'd63) begin
                    n_state = F_WR;
                end
            end
            F_SQ: begin
                if (r_x >= sq_t) begin
                    n_x = r_x - sq_t; n_r = (r_r >> 1) + r_bit;
                end else begin
                    n_r = r_r >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit == 64'd1) begin
                    n_state = F_WR;
                end
            end
            F_WR: begin
                v_we    = 1'b1;
                v_waddr = r_j[ADDR_W-1:0];
                if (res65[64:31] != {34{res65[64]}}) begin
                    n_err   = f_note(r_err, ERR_SAT);
                    v_wdata = res65[64] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
                end else begin
                    v_wdata = res65[31:0];
                end
                n_j = r_j + 1'b1; n_state = F_ENT0;
            end
            F_DONE: begin
                n_ov = 1'b1; n_okind = KIND_STATUS; n_oval = '0; n_ocode = r_err;
                n_factored = 1'b1; n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ec <= '0; r_rc <= '0; r_err <= ERR_NONE;
            r_factored <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_ec <= n_ec; r_rc <= n_rc; r_err <= n_err;
            r_factored <= n_factored; r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_okind <= n_okind; r_oval <= n_oval; r_ocode <= n_ocode;
        r_row <= n_row; r_col <= n_col; r_val <= n_val; r_last <= n_last; r_rdok <= n_rdok;
        r_i <= n_i; r_s <= n_s; r_e <= n_e; r_j <= n_j; r_ks <= n_ks; r_ke <= n_ke;
        r_pa <= n_pa; r_pb <= n_pb; r_k <= n_k; r_ca <= n_ca; r_a <= n_a; r_va <= n_va;
        r_acc <= n_acc; r_prod <= n_prod; r_num <= n_num; r_piv <= n_piv;
        r_rem <= n_rem; r_quo <= n_quo; r_cnt <= n_cnt; r_neg <= n_neg; r_isdiv <= n_isdiv;
        r_x <= n_x; r_r <= n_r; r_bit <= n_bit;
    end

    a_ec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ec <= EC_W'(MAX_ENTRIES)) else $error("entry count beyond capacity");

    a_rc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rc <= RC_W'(MAX_ROWS)) else $error("row count beyond capacity");

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("transfer taken while busy");

    a_div_pivot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_DIV) |-> (r_piv != '0)) else $error("division by zero pivot");

    a_status_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_DONE) |=> (m_axis_tvalid && m_axis_tuser == KIND_STATUS))
        else $error("status not presented after factorization");

endmodule
